// File: rtl/srr_pkg.sv
// shared types and constants for the selective-repeat receiver
// no dependencies; used by srr_slot_buf and selective_repeat_receiver
package srr_pkg;

  localparam int SLOTS     = 32;
  localparam int SLOT_AW   = $clog2(SLOTS);
  localparam int SEQ_W     = 8;
  localparam int WIN_W     = 5;
  localparam int LEN_W     = 10;
  localparam int HANDLE_W  = 16;
  localparam int STAMP_W   = 32;
  localparam int KIND_W    = 2;

  // buffered packets drained after the in-order one, at most
  localparam int MAX_DRAIN = (SLOTS - 1 < 31) ? SLOTS - 1 : 31;
  localparam int CNT_W     = $clog2(MAX_DRAIN + 1);

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NACK    = 2'd2;

  // configuration register indexes
  localparam logic REG_ADV_WINDOW  = 1'b0;
  localparam logic REG_ACCEPT_SPAN = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [HANDLE_W-1:0] handle;
  } slot_entry_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] idx;
    slot_entry_t        data;
  } slot_wr_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] idx;
  } slot_rd_t;

endpackage

// File: rtl/srr_slot_buf.sv
// slot buffer: entry memory with registered read plus per-slot valid flags
// depends on srr_pkg
module srr_slot_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srr_pkg::slot_wr_t    wr,
  input  srr_pkg::slot_rd_t    rd,
  output logic                 hit,
  output srr_pkg::slot_entry_t rd_data
);

  srr_pkg::slot_entry_t mem [srr_pkg::SLOTS];
  logic [srr_pkg::SLOTS-1:0] valid_r;

  // valid flag of the slot being probed
  assign hit = valid_r[rd.idx];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.idx];
    end
  end

  // a read drains the slot; a write fills it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rd.en) begin
        valid_r[rd.idx] <= 1'b0;
      end
      if (wr.en) begin
        valid_r[wr.idx] <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr.en && rd.en))
    else $error("slot read and write in the same cycle");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    rd.en |=> !valid_r[$past(rd.idx)])
    else $error("drained slot still valid");

  a_fill_sets: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> valid_r[$past(wr.idx)])
    else $error("written slot not valid");
`endif

endmodule

// File: rtl/selective_repeat_receiver.sv
// selective-repeat receiver top level: sequencer, output register, config registers
// depends on srr_pkg and srr_slot_buf
//
// channel   dir  handshake          payload
// in_       in   tvalid/tready      tdata packet fields, tuser flags
// out_      out  tvalid/tready      tdata result fields, tuser kind, tlast reply
// cfg_      in   wr_en (no wait)    addr register index, wdata value
//
// steps: bad, ahead or old packet: accept, evaluate, reply;
//   in-order packet: accept, evaluate, probe plus registered read per drained slot, reply
// each drained slot is read through the slot memory's single read port
// reset: synchronous active-low, clears expected number, slot valid flags,
//   config registers to 31 and the sequencer; no clearing pass needed
// stalls: a result waits in the output register; the sequencer holds until it is taken
module selective_repeat_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // seq_in[7:0], payload_len[17:8], stamp_in[49:18],
                                  // payload_ref[65:50], zero[71:66]
  input  logic [1:0]  in_tuser,   // decode_ok[0], truncated[1]
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // seq_out[7:0], window_out[12:8], len_out[22:13],
                                  // ref_out[38:23], stamp_out[70:39], zero[71]
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast,
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [4:0]  cfg_wdata
);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_PROBE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_REPLY = 3'd4;

  logic [2:0] state_r, state_nxt;

  // config registers
  logic [srr_pkg::WIN_W-1:0] adv_window_r;
  logic [4:0]                accept_span_r;

  // latched input item
  logic                         ok_r;
  logic [srr_pkg::SEQ_W-1:0]    seq_r;
  logic [srr_pkg::LEN_W-1:0]    len_r;
  logic [srr_pkg::STAMP_W-1:0]  stamp_r;
  logic [srr_pkg::HANDLE_W-1:0] handle_r;

  // link state
  logic [srr_pkg::SEQ_W-1:0] expected_r, expected_nxt;
  logic [srr_pkg::SEQ_W-1:0] next_r, next_nxt;
  logic [srr_pkg::CNT_W-1:0] drain_cnt_r, drain_cnt_nxt;
  logic [srr_pkg::KIND_W-1:0] reply_kind_r, reply_kind_nxt;

  // output register
  logic                         out_valid_r;
  logic [srr_pkg::KIND_W-1:0]   o_kind_r;
  logic [srr_pkg::SEQ_W-1:0]    o_seq_r;
  logic [srr_pkg::WIN_W-1:0]    o_win_r;
  logic [srr_pkg::LEN_W-1:0]    o_len_r;
  logic [srr_pkg::HANDLE_W-1:0] o_handle_r;
  logic [srr_pkg::STAMP_W-1:0]  o_stamp_r;
  logic                         o_last_r;

  // emit request from the sequencer
  logic                         emit;
  logic [srr_pkg::KIND_W-1:0]   e_kind;
  logic [srr_pkg::SEQ_W-1:0]    e_seq;
  logic [srr_pkg::WIN_W-1:0]    e_win;
  logic [srr_pkg::LEN_W-1:0]    e_len;
  logic [srr_pkg::HANDLE_W-1:0] e_handle;
  logic [srr_pkg::STAMP_W-1:0]  e_stamp;
  logic                         e_last;

  logic out_free;
  logic in_acc;

  // slot buffer
  srr_pkg::slot_wr_t    slot_wr;
  srr_pkg::slot_rd_t    slot_rd;
  logic                 slot_hit;
  srr_pkg::slot_entry_t slot_q;

  // distance and span compare, datapath of the evaluate step
  logic [srr_pkg::SEQ_W-1:0] seq_gap;
  logic [srr_pkg::SEQ_W-1:0] eff_span;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign seq_gap  = seq_r - expected_r;
  assign eff_span = (accept_span_r > 5'(srr_pkg::SLOTS - 1))
                    ? srr_pkg::SEQ_W'(srr_pkg::SLOTS - 1)
                    : srr_pkg::SEQ_W'(accept_span_r);

  srr_slot_buf u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (slot_wr),
    .rd      (slot_rd),
    .hit     (slot_hit),
    .rd_data (slot_q)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    expected_nxt   = expected_r;
    next_nxt       = next_r;
    drain_cnt_nxt  = drain_cnt_r;
    reply_kind_nxt = reply_kind_r;
    emit           = 1'b0;
    e_kind         = srr_pkg::KIND_DELIVER;
    e_seq          = '0;
    e_win          = '0;
    e_len          = '0;
    e_handle       = '0;
    e_stamp        = '0;
    e_last         = 1'b0;
    slot_wr        = '0;
    slot_rd        = '0;
    slot_rd.idx    = srr_pkg::SLOT_AW'(next_r % srr_pkg::SLOTS);
    slot_wr.idx    = srr_pkg::SLOT_AW'(seq_r % srr_pkg::SLOTS);
    slot_wr.data   = '{len: len_r, handle: handle_r};
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        reply_kind_nxt = srr_pkg::KIND_ACK;
        if (!ok_r) begin
          // bad or truncated packet
          reply_kind_nxt = srr_pkg::KIND_NACK;
          state_nxt      = ST_REPLY;
        end else if (seq_r == expected_r) begin
          // in-order: deliver it, then walk the buffered run
          if (out_free) begin
            emit          = 1'b1;
            e_seq         = seq_r;
            e_len         = len_r;
            e_handle      = handle_r;
            next_nxt      = seq_r + 8'd1;
            drain_cnt_nxt = '0;
            state_nxt     = ST_PROBE;
          end
        end else begin
          // ahead within span: buffer; old or far: only acknowledge
          slot_wr.en = (seq_gap != 8'd0) && (seq_gap <= eff_span);
          state_nxt  = ST_REPLY;
        end
      end
      ST_PROBE: begin
        if (slot_hit && (drain_cnt_r < srr_pkg::CNT_W'(srr_pkg::MAX_DRAIN))) begin
          slot_rd.en = 1'b1;
          state_nxt  = ST_DRAIN;
        end else begin
          expected_nxt = next_r;
          state_nxt    = ST_REPLY;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          emit          = 1'b1;
          e_seq         = next_r;
          e_len         = slot_q.len;
          e_handle      = slot_q.handle;
          next_nxt      = next_r + 8'd1;
          drain_cnt_nxt = drain_cnt_r + 1'b1;
          state_nxt     = ST_PROBE;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = reply_kind_r;
          e_seq     = expected_r - 8'd1;
          e_win     = adv_window_r;
          e_stamp   = stamp_r;
          e_last    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      expected_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      expected_r <= expected_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    next_r       <= next_nxt;
    drain_cnt_r  <= drain_cnt_nxt;
    reply_kind_r <= reply_kind_nxt;
    if (in_acc) begin
      ok_r     <= in_tuser[0] && !in_tuser[1];
      seq_r    <= in_tdata[7:0];
      len_r    <= in_tdata[17:8];
      stamp_r  <= in_tdata[49:18];
      handle_r <= in_tdata[65:50];
    end
    if (emit) begin
      o_kind_r   <= e_kind;
      o_seq_r    <= e_seq;
      o_win_r    <= e_win;
      o_len_r    <= e_len;
      o_handle_r <= e_handle;
      o_stamp_r  <= e_stamp;
      o_last_r   <= e_last;
    end
  end

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adv_window_r  <= 5'd31;
      accept_span_r <= 5'd31;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        srr_pkg::REG_ADV_WINDOW:  adv_window_r  <= cfg_wdata;
        srr_pkg::REG_ACCEPT_SPAN: accept_span_r <= cfg_wdata;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {1'b0, o_stamp_r, o_handle_r, o_len_r, o_win_r, o_seq_r};

`ifndef NO_ASSERTIONS
  a_deliver_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (o_kind_r == srr_pkg::KIND_DELIVER) |-> !o_last_r)
    else $error("delivery marked as reply");

  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE || state_r == ST_DRAIN)
      |-> drain_cnt_r <= srr_pkg::CNT_W'(srr_pkg::MAX_DRAIN))
    else $error("drain count past bound");

  a_expected_moves_on_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) && (expected_r != $past(expected_r))
      |-> $past(state_r) == ST_PROBE)
    else $error("expected number changed outside probe exit");

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result overwrote a pending item");
`endif

endmodule
